// File: hw/rtl/asc_pkg.sv
// Shared constants, types and register codes of the adaptive sample count selector.
package asc_pkg;

    // Ring geometry and field widths.
    localparam int HIST_DEPTH = 10;
    localparam int SMP_W      = 24;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int CNT_W      = 10;
    localparam int THR_W      = 23;
    localparam int STEPS_W    = 8;
    localparam int VAR_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Running sums of the ring and the exact variance numerator.
    localparam int S1_W   = SMP_W + PTR_W;
    localparam int S2_W   = 2 * SMP_W - 1 + PTR_W;
    localparam int MUL_W  = (S1_W > THR_W) ? S1_W : THR_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NN     = HIST_DEPTH * HIST_DEPTH;
    localparam int NUM_W  = S2_W + PTR_W;
    localparam int T2_W   = 2 * THR_W + 2 * PTR_W;
    localparam int CMP_W  = (NUM_W > T2_W + 2) ? NUM_W : T2_W + 2;

    // Divider timing: the variance quotient takes eight bits a cycle and the
    // count step two bits a cycle; both run side by side.
    localparam int VREM_W    = $clog2(NN);
    localparam int VDIV_STEP = 8;
    localparam int VDIV_CYC  = (NUM_W + VDIV_STEP - 1) / VDIV_STEP;
    localparam int VDIV_PAD  = VDIV_CYC * VDIV_STEP;
    localparam int CDIV_STEP = 2;
    localparam int CDIV_CYC  = (CNT_W + CDIV_STEP - 1) / CDIV_STEP;
    localparam int CDIV_PAD  = CDIV_CYC * CDIV_STEP;
    localparam int DIV_CYC   = (VDIV_CYC > CDIV_CYC) ? VDIV_CYC : CDIV_CYC;
    localparam int DCNT_W    = $clog2(DIV_CYC);

    // Register reset values.
    localparam logic [THR_W-1:0]   THR_RST   = THR_W'(1280);
    localparam logic [CNT_W-1:0]   MIN_RST   = CNT_W'(10);
    localparam logic [CNT_W-1:0]   MAX_RST   = CNT_W'(50);
    localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_MIN       = 3'd2,
        CFG_MAX       = 3'd3,
        CFG_STEPS     = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SQ_NEW,
        ST_ACC,
        ST_T2,
        ST_NUM,
        ST_CMP,
        ST_DIV,
        ST_UPD,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [CNT_W-1:0]   mag;
        logic [STEPS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAR_W-1:0] variance;
        logic [CNT_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: hw/rtl/asc_in_if.sv
// Input channel carrying one weight sample per transaction.
interface asc_in_if
    import asc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] weight_sample;

    modport source (output valid, output weight_sample, input ready);
    modport sink (input valid, input weight_sample, output ready);
endinterface

// File: hw/rtl/asc_out_if.sv
// Result channel carrying the chosen count, the variance and the ring status.
interface asc_out_if
    import asc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] sample_count;
    logic [VAR_W-1:0] history_variance;
    logic             history_full;

    modport source (output valid, output sample_count, output history_variance,
                    output history_full, input ready);
    modport sink (input valid, input sample_count, input history_variance,
                  input history_full, output ready);
endinterface

// File: hw/rtl/asc_ring_mem.sv
// Sample ring storage: one write port and one registered read port.
module asc_ring_mem
    import asc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [PTR_W-1:0] i_rd_addr,
    output logic [SMP_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [PTR_W-1:0] i_wr_addr,
    input  logic [SMP_W-1:0] i_wr_data
);
    logic [SMP_W-1:0] r_mem [HIST_DEPTH];
    logic [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hw/rtl/asc_div_unit.sv
// Multi-cycle divider: variance numerator by depth squared, and count delta by step count.
module asc_div_unit
    import asc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam logic [VREM_W:0] NN_C = (VREM_W + 1)'(NN);

    logic                r_busy;
    logic [DCNT_W-1:0]   r_cnt;
    logic                last;
    logic [VDIV_PAD-1:0] r_vq, n_vq;
    logic [VREM_W-1:0]   r_vrem, n_vrem;
    logic [VREM_W:0]     v_try;
    logic [CDIV_PAD-1:0] r_cq, n_cq;
    logic [STEPS_W-1:0]  r_crem, n_crem, r_div;
    logic [STEPS_W:0]    c_try;
    logic                v_run, c_run;

    assign last  = r_busy && (r_cnt == DCNT_W'(DIV_CYC - 1));
    assign v_run = ({1'b0, r_cnt} < (DCNT_W + 1)'(VDIV_CYC));
    assign c_run = ({1'b0, r_cnt} < (DCNT_W + 1)'(CDIV_CYC));

    // Restoring division by the constant depth squared, several bits a cycle.
    always_comb begin
        n_vq   = r_vq;
        n_vrem = r_vrem;
        v_try  = '0;
        for (int k = 0; k < VDIV_STEP; k++) begin
            v_try = {n_vrem, n_vq[VDIV_PAD-1]};
            n_vq  = {n_vq[VDIV_PAD-2:0], 1'b0};
            if (v_try >= NN_C) begin
                v_try   = v_try - NN_C;
                n_vq[0] = 1'b1;
            end
            n_vrem = v_try[VREM_W-1:0];
        end
    end

    // Restoring division of the count delta magnitude by the step count.
    always_comb begin
        n_cq   = r_cq;
        n_crem = r_crem;
        c_try  = '0;
        for (int k = 0; k < CDIV_STEP; k++) begin
            c_try = {n_crem, n_cq[CDIV_PAD-1]};
            n_cq  = {n_cq[CDIV_PAD-2:0], 1'b0};
            if (c_try >= {1'b0, r_div}) begin
                c_try   = c_try - {1'b0, r_div};
                n_cq[0] = 1'b1;
            end
            n_crem = c_try[STEPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vq   <= VDIV_PAD'(i_req.num);
            r_vrem <= '0;
            r_cq   <= CDIV_PAD'(i_req.mag) << (CDIV_PAD - CNT_W);
            r_crem <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            if (v_run) begin
                r_vq   <= n_vq;
                r_vrem <= n_vrem;
            end
            if (c_run) begin
                r_cq   <= n_cq;
                r_crem <= n_crem;
            end
        end
    end

    assign o_rsp.done     = last;
    assign o_rsp.variance = VAR_W'(r_vq);
    assign o_rsp.quot     = CNT_W'(r_cq);
endmodule

// File: hw/rtl/adaptive_sample_count_selector_core.sv
// Top level of the adaptive sample count selector: sequencer, running sums and count update.
//
//   Channel   Direction  Handshake        Payload
//   i_smp     in         valid / ready    weight_sample (24-bit signed)
//   o_res     out        valid / ready    sample_count, history_variance, history_full
//   i_cfg_*   in         write enable     register index, write data
//
// One sample is worked on at a time. With adaptive counting disabled or the ring
// not yet full an item skips the threshold compare and the divide; otherwise the
// divider unit produces the variance quotient eight bits a cycle.
// The ring is updated by reading the entry about to be overwritten and adjusting
// the running sums, so each item costs one ring read and one ring write.
// Reset is synchronous; no clearing pass is needed since the fill count masks
// entries that were never written. A stalled result waits in the output register
// while the next sample is already taken in.
module adaptive_sample_count_selector_core
    import asc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    asc_in_if.sink                i_smp,
    asc_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_state r_state, n_state;

    logic               r_cfg_en;
    logic [THR_W-1:0]   r_cfg_thr;
    logic [CNT_W-1:0]   r_cfg_min;
    logic [CNT_W-1:0]   r_cfg_max;
    logic [STEPS_W-1:0] r_cfg_steps;

    logic [PTR_W-1:0]         r_wp;
    logic [FILL_W-1:0]        r_fill;
    logic [CNT_W-1:0]         r_count;
    logic [VAR_W-1:0]         r_last_var;
    logic signed [SMP_W-1:0]  r_x_new;
    logic signed [S1_W-1:0]   r_s1;
    logic [S2_W-1:0]          r_s2;
    logic [PROD_W-1:0]        r_prod;
    logic [T2_W-1:0]          r_t2;
    logic [NUM_W-1:0]         r_num;
    logic                     r_snap, r_neg, r_dnz;
    logic [CNT_W-1:0]         r_res_count;
    logic                     r_ov;
    logic [CNT_W-1:0]         r_o_count;
    logic [VAR_W-1:0]         r_o_var;
    logic                     r_o_full;

    logic                     accept, push, full;
    logic [SMP_W-1:0]         rd_data;
    logic signed [SMP_W-1:0]  x_old;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [PROD_W-1:0] mul_p;

    logic [CMP_W-1:0]         num_c, t2_c;
    logic                     ge4, lt1;
    logic [CNT_W-1:0]         target, mag;
    logic signed [CNT_W:0]    delta, neg_delta;

    logic [CNT_W-1:0]         step_mag, new_count;
    logic signed [CNT_W+1:0]  step, c_sum, c_lo, c_cl, min_s, max_s;

    t_div_req div_req;
    t_div_rsp div_rsp;

    assign accept = i_smp.valid && i_smp.ready;
    assign full   = (r_fill == FILL_W'(HIST_DEPTH));

    // An entry not yet written while the ring fills counts as zero.
    assign x_old = full ? signed'(rd_data) : '0;

    asc_ring_mem u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_wp),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == ST_RD),
        .i_wr_addr (r_wp),
        .i_wr_data (r_x_new)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        push        = 1'b0;
        i_smp.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_smp.ready = 1'b1;
                if (i_smp.valid) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:     n_state = ST_SQ_NEW;
            ST_SQ_NEW: n_state = ST_ACC;
            ST_ACC: begin
                n_state = (r_cfg_en && full) ? ST_T2 : ST_PUSH;
            end
            ST_T2:  n_state = ST_NUM;
            ST_NUM: n_state = ST_CMP;
            ST_CMP: n_state = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: n_state = ST_PUSH;
            ST_PUSH: begin
                if (!r_ov || o_res.ready) begin
                    push    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // One shared squarer serves old sample, new sample, threshold and sum in turn.
    always_comb begin
        case (r_state)
            ST_RD:     mul_a = MUL_W'(x_old);
            ST_SQ_NEW: mul_a = MUL_W'(r_x_new);
            ST_ACC:    mul_a = signed'(MUL_W'(r_cfg_thr));
            ST_T2:     mul_a = MUL_W'(r_s1);
            default:   mul_a = '0;
        endcase
    end

    assign mul_p = mul_a * mul_a;

    // Threshold compares on the exact numerator.
    always_comb begin
        num_c     = CMP_W'(r_num);
        t2_c      = CMP_W'(r_t2);
        ge4       = (num_c >= (t2_c << 2));
        lt1       = (num_c < t2_c);
        target    = lt1 ? r_cfg_max : r_cfg_min;
        delta     = signed'({1'b0, target}) - signed'({1'b0, r_count});
        neg_delta = -delta;
        mag       = delta[CNT_W] ? neg_delta[CNT_W-1:0] : delta[CNT_W-1:0];
    end

    assign div_req.start   = (r_state == ST_CMP);
    assign div_req.num     = r_num;
    assign div_req.mag     = mag;
    assign div_req.divisor = (r_cfg_steps == '0) ? STEPS_W'(1) : r_cfg_steps;

    asc_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Count update: ge4 gives min; a non-zero move is at least one, clamped to min and max.
    always_comb begin
        step_mag  = (div_rsp.quot == '0 && r_dnz) ? CNT_W'(1) : div_rsp.quot;
        step      = r_neg ? -signed'({2'b00, step_mag}) : signed'({2'b00, step_mag});
        c_sum     = signed'({2'b00, r_count}) + step;
        min_s     = signed'({2'b00, r_cfg_min});
        max_s     = signed'({2'b00, r_cfg_max});
        c_lo      = (c_sum < min_s) ? min_s : c_sum;
        c_cl      = (c_lo > max_s) ? max_s : c_lo;
        new_count = r_snap ? r_cfg_min : c_cl[CNT_W-1:0];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en    <= 1'b0;
            r_cfg_thr   <= THR_RST;
            r_cfg_min   <= MIN_RST;
            r_cfg_max   <= MAX_RST;
            r_cfg_steps <= STEPS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:    r_cfg_en    <= i_cfg_data[0];
                CFG_THRESHOLD: r_cfg_thr   <= i_cfg_data[THR_W-1:0];
                CFG_MIN:       r_cfg_min   <= i_cfg_data[CNT_W-1:0];
                CFG_MAX:       r_cfg_max   <= i_cfg_data[CNT_W-1:0];
                CFG_STEPS:     r_cfg_steps <= i_cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Ring pointers, running sums and kept count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_fill     <= '0;
            r_s1       <= '0;
            r_s2       <= '0;
            r_count    <= MIN_RST;
            r_last_var <= '0;
            r_ov       <= 1'b0;
        end else begin
            case (r_state)
                ST_RD: begin
                    r_s1 <= r_s1 + S1_W'(r_x_new) - S1_W'(x_old);
                    r_wp <= (r_wp == PTR_W'(HIST_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    if (!full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                ST_SQ_NEW: r_s2 <= r_s2 - S2_W'(r_prod);
                ST_ACC:    r_s2 <= r_s2 + S2_W'(r_prod);
                ST_UPD: begin
                    r_count    <= new_count;
                    r_last_var <= div_rsp.variance;
                end
                default: ;
            endcase
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge i_clk) begin
        r_prod <= $unsigned(mul_p);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_x_new <= i_smp.weight_sample;
                end
            end
            ST_ACC: r_res_count <= r_cfg_min;
            ST_T2:  r_t2 <= T2_W'(r_prod) * T2_W'(NN);
            ST_NUM: r_num <= NUM_W'(r_s2) * NUM_W'(HIST_DEPTH) - NUM_W'(r_prod);
            ST_CMP: begin
                r_snap <= ge4;
                r_neg  <= delta[CNT_W];
                r_dnz  <= (delta != '0);
            end
            ST_UPD: r_res_count <= new_count;
            default: ;
        endcase
        if (push) begin
            r_o_count <= r_res_count;
            r_o_var   <= r_last_var;
            r_o_full  <= full;
        end
    end

    assign o_res.valid            = r_ov;
    assign o_res.sample_count     = r_o_count;
    assign o_res.history_variance = r_o_var;
    assign o_res.history_full     = r_o_full;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("Fill level has run past the ring depth.");

    a_wp_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> (r_wp == PTR_W'(r_fill)))
        else $error("Write pointer and fill level disagree while the ring fills.");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RD))
        else $error("Accepted sample did not start a ring update.");

    a_div_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("Divider finished outside the divide phase.");
endmodule

// File: tb/asc_count_checker.sv
// Predicts the count, variance and full flag of every sample and compares each result.
`timescale 1ns / 100ps
module asc_count_checker
    import asc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    asc_in_if                     i_smp,
    asc_out_if                    i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [VAR_W-1:0] variance;
        logic             full;
    } t_count_result;

    logic                    reg_enable;
    logic [THR_W-1:0]        reg_threshold;
    logic [CNT_W-1:0]        reg_min;
    logic [CNT_W-1:0]        reg_max;
    logic [STEPS_W-1:0]      reg_steps;

    logic signed [SMP_W-1:0] ring [HIST_DEPTH];
    int                      ring_pos;
    int                      ring_fill;
    logic [CNT_W-1:0]        kept_count;
    logic [VAR_W-1:0]        kept_variance;

    t_count_result           due_results [$];
    int                      fail_total = 0;

    assign o_fail_count = fail_total;

    // Stores the sample, then picks the count exactly as the block should.
    function automatic t_count_result choose_count(input logic signed [SMP_W-1:0] weight);
        t_count_result r;
        longint        sum1;
        longint        sum2;
        longint        num;
        longint        thr_sq;
        longint        delta;
        longint        divisor;
        longint        step;
        longint        next;
        ring[ring_pos] = weight;
        ring_pos = (ring_pos == HIST_DEPTH - 1) ? 0 : ring_pos + 1;
        if (ring_fill < HIST_DEPTH) ring_fill++;
        r.full = (ring_fill >= HIST_DEPTH);
        if (!reg_enable || !r.full) begin
            r.count = reg_min;
        end else begin
            sum1 = 0;
            sum2 = 0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                sum1 += longint'(ring[i]);
                sum2 += longint'(ring[i]) * longint'(ring[i]);
            end
            // N*N times the population variance, compared against N*N*T*T without a root.
            num = HIST_DEPTH * sum2 - sum1 * sum1;
            kept_variance = VAR_W'(num / NN);
            thr_sq = longint'(reg_threshold) * longint'(reg_threshold) * NN;
            if (num >= 4 * thr_sq) begin
                kept_count = reg_min;
            end else begin
                delta = (num < thr_sq ? longint'(reg_max) : longint'(reg_min))
                        - longint'(kept_count);
                divisor = (reg_steps == 0) ? 1 : longint'(reg_steps);
                step = delta / divisor;
                if (step == 0 && delta != 0) step = (delta > 0) ? 1 : -1;
                next = longint'(kept_count) + step;
                // The minimum is applied first, so a maximum below it wins.
                if (next < longint'(reg_min)) next = longint'(reg_min);
                if (next > longint'(reg_max)) next = longint'(reg_max);
                kept_count = CNT_W'(next);
            end
            r.count = kept_count;
        end
        r.variance = kept_variance;
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_count_result want;
        if (!i_rst_n) begin
            reg_enable    = 1'b0;
            reg_threshold = THR_RST;
            reg_min       = MIN_RST;
            reg_max       = MAX_RST;
            reg_steps     = STEPS_RST;
            for (int i = 0; i < HIST_DEPTH; i++) ring[i] = '0;
            ring_pos      = 0;
            ring_fill     = 0;
            kept_count    = MIN_RST;
            kept_variance = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:    reg_enable    = i_cfg_data[0];
                    CFG_THRESHOLD: reg_threshold = i_cfg_data[THR_W-1:0];
                    CFG_MIN:       reg_min       = i_cfg_data[CNT_W-1:0];
                    CFG_MAX:       reg_max       = i_cfg_data[CNT_W-1:0];
                    CFG_STEPS:     reg_steps     = i_cfg_data[STEPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready) begin
                due_results.push_back(choose_count(i_smp.weight_sample));
            end
            if (i_res.valid && i_res.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, count %0d variance %0d full %0b",
                             $time, i_res.sample_count, i_res.history_variance,
                             i_res.history_full);
                    fail_total++;
                end else begin
                    want = due_results.pop_front();
                    if (i_res.sample_count !== want.count) begin
                        $display("%0t: sample_count expected %0d, actual %0d",
                                 $time, want.count, i_res.sample_count);
                        fail_total++;
                    end
                    if (i_res.history_variance !== want.variance) begin
                        $display("%0t: history_variance expected %0d, actual %0d",
                                 $time, want.variance, i_res.history_variance);
                        fail_total++;
                    end
                    if (i_res.history_full !== want.full) begin
                        $display("%0t: history_full expected %0b, actual %0b",
                                 $time, want.full, i_res.history_full);
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the testbench: clock, reset, register set-up, sample stimulus and the verdict.
`timescale 1ns / 100ps
module tb_top;
    import asc_pkg::*;

    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 102;
    localparam int PRESSURE_PHASE = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic signed [SMP_W-1:0] W_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] W_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int                    tx_idle_pct = 38;
    int                    rx_idle_pct = 88;
    bit                    hold_req = 1'b0;
    logic [THR_W-1:0]      cur_thr = THR_RST;
    longint                regime_base = 0;
    longint                regime_spread = 0;

    asc_in_if  smp_if ();
    asc_out_if res_if ();

    adaptive_sample_count_selector_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    asc_count_checker count_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_smp        (smp_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic program_block(input logic en, input logic [THR_W-1:0] thr,
                                 input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi,
                                 input logic [STEPS_W-1:0] steps);
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_MIN, CFG_DATA_W'(lo));
        write_reg(CFG_MAX, CFG_DATA_W'(hi));
        write_reg(CFG_STEPS, CFG_DATA_W'(steps));
        cfg_we  <= 1'b0;
        cur_thr = thr;
    endtask

    // Valid is left high after a transaction so back-to-back samples need no gap.
    task automatic offer_sample(input logic signed [SMP_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        smp_if.valid         <= 1'b1;
        smp_if.weight_sample <= value;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
    endtask

    task automatic settle_block();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly samples scattered around the current regime, with some noise and extremes.
    function automatic logic signed [SMP_W-1:0] draw_weight();
        int     pick;
        longint v;
        pick = $urandom_range(0, 99);
        if (pick < 8) return SMP_W'($urandom);
        if (pick < 12) begin
            case ($urandom_range(0, 3))
                0: return W_MAX;
                1: return W_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        v = regime_base + longint'($urandom_range(0, 32'(2 * regime_spread))) - regime_spread;
        if (v > longint'(W_MAX)) v = longint'(W_MAX);
        if (v < longint'(W_MIN)) v = longint'(W_MIN);
        return SMP_W'(v);
    endfunction

    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                // One long hold-off so that the output fills and the input stalls.
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int                      left;
        int                      a;
        int                      b;
        logic                    en;
        logic [THR_W-1:0]        thr;
        logic [CNT_W-1:0]        lo;
        logic [CNT_W-1:0]        hi;
        logic [STEPS_W-1:0]      steps;
        logic signed [SMP_W-1:0] extremes [10];
        extremes = '{W_MAX, W_MIN, '1, 24'sd1, 24'sh555555, 24'shAAAAAA, '0,
                     W_MAX, W_MIN, 24'sd1};
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_ENABLE;
        cfg_data             <= '0;
        smp_if.valid         <= 1'b0;
        smp_if.weight_sample <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: disabled, so the minimum count comes back.
        offer_sample(W_MAX);
        offer_sample(W_MIN);
        offer_sample('0);
        settle_block();
        program_block(1'b1, THR_RST, MIN_RST, MAX_RST, STEPS_RST);
        // The ring fills with extremes, which snaps the count to the minimum,
        // then a flat run drains the spread and the count climbs.
        foreach (extremes[i]) offer_sample(extremes[i]);
        repeat (12) offer_sample(24'sd1000);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_block();
            en = ($urandom_range(0, 9) != 0);
            thr = THR_W'($urandom_range(1, 8388607) >> $urandom_range(0, 22));
            if (thr == 0) thr = 1;
            a = $urandom_range(1, 1023);
            b = $urandom_range(1, 1023);
            lo = CNT_W'((a < b) ? a : b);
            hi = CNT_W'((a < b) ? b : a);
            steps = STEPS_W'($urandom_range(1, 255));
            case (ph)
                0: en = 1'b0;
                1: begin
                    en = 1'b1; thr = 1; lo = 1; hi = 1023; steps = 1;
                end
                2: begin
                    en = 1'b1; thr = '1; lo = 1023; hi = 1023; steps = 255;
                end
                3: begin
                    en = 1'b1; thr = '0;
                end
                4: begin
                    en = 1'b1; lo = 1; hi = 1023; steps = 255;
                end
                5: begin
                    en = 1'b1; steps = '0;
                end
                6: begin
                    en = 1'b1; lo = 10'd600; hi = 10'd200;
                end
                7: begin
                    en = 1'b1; lo = '0;
                end
                default: ;
            endcase
            program_block(en, thr, lo, hi, steps);

            if (ph < 5) begin
                tx_idle_pct = 38;
                rx_idle_pct = 88;
            end else if (ph < 10) begin
                tx_idle_pct = 88;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == PRESSURE_PHASE) hold_req = 1'b1;

            left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (left == 0) begin
                    // A spread of up to five thresholds reaches every variance band.
                    regime_base = longint'($urandom_range(0, 32'h7FFFFF)) - 64'sd4194304;
                    regime_spread = longint'(cur_thr) * $urandom_range(0, 20) / 4;
                    if (regime_spread > 64'sd8388608) regime_spread = 64'sd8388608;
                    left = $urandom_range(8, 30);
                end
                left--;
                offer_sample(draw_weight());
            end
        end

        settle_block();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/asc_pkg.sv
hw/rtl/asc_in_if.sv
hw/rtl/asc_out_if.sv
hw/rtl/asc_ring_mem.sv
hw/rtl/asc_div_unit.sv
hw/rtl/adaptive_sample_count_selector_core.sv
tb/asc_count_checker.sv
tb/tb_top.sv
